>>> sv/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg
// shared widths, reset values and register codes of the 5x5 sliding max core
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int PIX_W      = 32;
  localparam int ROW_W      = 16;
  localparam int COL_W      = 10;
  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
  localparam logic [FH_W-1:0] FH_RESET = 16'd1024;

  typedef logic signed [PIX_W-1:0] pix_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

endpackage

>>> sv/sliding_max_5x5_core.sv
// path: an accepted pixel passes the s1 registers, the column window and s2 registers,
// then the output register, where out_valid_o rises; rates below assume no output stall
// throughput: one pixel per cycle; a row's last pixel or a last-row pixel releases up to
// RADIUS+1 results, the frame's last pixel (RADIUS+1)^2, one per cycle, input held meanwhile
// reset (rst_ni low, asynchronous): handshakes idle, position (0,0), width and height 1024
// line memory not cleared: rows not yet seen in a frame are masked by the row position
// ----------------------------------------------------------------------------
// sliding_max_5x5_core
// streaming grey-scale dilation: maximum over a clipped square window around
// every pixel, one column-history memory plus a register window of columns
// ----------------------------------------------------------------------------
module sliding_max_5x5_core #(
  parameter int MAX_WIDTH = 1024,
  parameter int RADIUS    = 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // register write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [smx_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [smx_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // pixel requests
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [smx_pkg::PIX_W-1:0]     pixel_value_i,
  // result requests
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [smx_pkg::ROW_W-1:0]            out_row_o,
  output logic [smx_pkg::COL_W-1:0]            out_col_o,
  output logic signed [smx_pkg::PIX_W-1:0]     window_max_o,
  output logic                                 last_of_run_o
);

  // window geometry
  localparam int SPAN  = 2 * RADIUS + 1;          // rows or columns in a full window
  localparam int HIST  = 2 * RADIUS;              // earlier rows kept per column
  localparam int NV    = RADIUS + 1;              // vertical maxima kept per column
  localparam int CW    = $clog2(MAX_WIDTH);       // column counter / memory address
  localparam int KW    = $clog2(RADIUS + 1);      // offset of a due result from the pixel
  localparam int MEM_W = HIST * smx_pkg::PIX_W;

  localparam logic [smx_pkg::ROW_W-1:0] R_ROW = smx_pkg::ROW_W'(RADIUS);
  localparam logic [CW-1:0]             R_COL = CW'(RADIUS);
  localparam logic [KW-1:0]             R_K   = KW'(RADIUS);

  // --------------------------------------------------------------------------
  // configuration registers, always ready
  // --------------------------------------------------------------------------
  logic [smx_pkg::FW_W-1:0] fw_q;
  logic [smx_pkg::FH_W-1:0] fh_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= smx_pkg::FW_RESET;
      fh_q <= smx_pkg::FH_RESET;
    end else if (cfg_valid_i) begin
      // an index past the register list is ignored
      if (cfg_index_i == smx_pkg::CFG_FRAME_WIDTH) begin
        fw_q <= cfg_data_i[smx_pkg::FW_W-1:0];
      end else if (cfg_index_i == smx_pkg::CFG_FRAME_HEIGHT) begin
        fh_q <= cfg_data_i[smx_pkg::FH_W-1:0];
      end
    end
  end

  // last column and last row of the frame; zero acts as one, width capped at the memory
  logic [CW-1:0]             wm1;
  logic [smx_pkg::ROW_W-1:0] hm1;

  always_comb begin
    if (fw_q == '0) begin
      wm1 = '0;
    end else if (32'(fw_q) >= 32'(MAX_WIDTH)) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(fw_q - smx_pkg::FW_W'(1));
    end
    hm1 = (fh_q == '0) ? '0 : smx_pkg::ROW_W'(fh_q - smx_pkg::FH_W'(1));
  end

  // --------------------------------------------------------------------------
  // pipeline handshake
  //   s1: column history read back from memory, vertical maxima, write back
  //   s2: horizontal maxima over the column window, one result per cycle while out is free
  //   out: result register towards the consumer
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic accept, out_free, s2_go, s2_last, s2_done, s1_adv;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s2_go      = s2_valid_q && out_free;
  assign s2_done    = s2_go && s2_last;
  // window registers shift on an s1 advance, so s2 must have handed out its last result
  assign s1_adv     = s1_valid_q && (!s2_valid_q || s2_done);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // position counters and the results a pixel makes due
  // --------------------------------------------------------------------------
  logic [smx_pkg::ROW_W-1:0] row_q, row_d;
  logic [CW-1:0]             col_q, col_d;
  logic                      drop_row, drop_col, in_frame, row_end, col_end;
  logic                      row_due, col_due;
  logic [KW-1:0]             krhi, krlo, kchi, kclo;

  always_comb begin
    drop_row = row_q > hm1;
    drop_col = col_q > wm1;
    in_frame = !drop_row && !drop_col;
    row_end  = row_q == hm1;
    col_end  = col_q == wm1;

    // on the last row the rows above it that still wait are released too
    row_due  = row_end || (row_q >= R_ROW);
    krhi     = (row_end && (row_q < R_ROW)) ? KW'(row_q) : R_K;
    krlo     = row_end ? '0 : R_K;
    col_due  = col_end || (col_q >= R_COL);
    kchi     = (col_end && (col_q < R_COL)) ? KW'(col_q) : R_K;
    kclo     = col_end ? '0 : R_K;

    row_d = row_q;
    col_d = col_q;
    if (accept) begin
      if (drop_row) begin
        // outside the frame after a height change: restart the frame
        row_d = '0;
        col_d = '0;
      end else if (drop_col || col_end) begin
        col_d = '0;
        row_d = (row_q >= hm1) ? '0 : row_q + smx_pkg::ROW_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // --------------------------------------------------------------------------
  // s1 registers
  // --------------------------------------------------------------------------
  smx_pkg::pix_t             pix1_q;
  logic [smx_pkg::ROW_W-1:0] row1_q;
  logic [CW-1:0]             col1_q;
  logic                      due1_q;
  logic [KW-1:0]             krhi1_q, krlo1_q, kchi1_q, kclo1_q;
  logic                      fwd_q;
  logic [MEM_W-1:0]          fwd_data_q;
  logic [MEM_W-1:0]          rdata_q;
  logic [MEM_W-1:0]          mem_wdata;
  logic                      mem_re, mem_we;

  // pixels outside the frame are consumed here and never enter the pipeline
  assign mem_re = accept && in_frame;
  assign mem_we = s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= in_frame;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      pix1_q     <= pixel_value_i;
      row1_q     <= row_q;
      col1_q     <= col_q;
      due1_q     <= row_due && col_due;
      krhi1_q    <= krhi;
      krlo1_q    <= krlo;
      kchi1_q    <= kchi;
      kclo1_q    <= kclo;
      // same column written back in this cycle (one-pixel-wide frame): take the new word
      fwd_q      <= mem_we && (col1_q == col_q);
      fwd_data_q <= mem_wdata;
    end
  end

  // column history: HIST earlier rows of each column, newest in the low word
  logic [MEM_W-1:0] line_mem_q [MAX_WIDTH];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem_q[col1_q] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= line_mem_q[col_q];
    end
  end

  // vertical suffix maxima, rows above the frame top are skipped
  logic [MEM_W-1:0] hist;
  smx_pkg::pix_t    colv [SPAN];
  smx_pkg::pix_t    vs   [SPAN];
  smx_pkg::pix_t    vcur [NV];

  always_comb begin
    hist      = fwd_q ? fwd_data_q : rdata_q;
    mem_wdata = {hist[(HIST-1)*smx_pkg::PIX_W-1:0], pix1_q};
    colv[0]   = pix1_q;
    for (int i = 1; i < SPAN; i++) begin
      colv[i] = hist[(i-1)*smx_pkg::PIX_W +: smx_pkg::PIX_W];
    end
    vs[0] = colv[0];
    for (int i = 1; i < SPAN; i++) begin
      vs[i] = ((row1_q >= smx_pkg::ROW_W'(i)) && (colv[i] > vs[i-1])) ? colv[i] : vs[i-1];
    end
    // vcur[k]: maximum over this row and the RADIUS+k rows above it
    for (int k = 0; k < NV; k++) begin
      vcur[k] = vs[k + RADIUS];
    end
  end

  // --------------------------------------------------------------------------
  // column window: vertical maxima of this column and the HIST columns before it
  // --------------------------------------------------------------------------
  smx_pkg::pix_t win_q [SPAN][NV];

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      win_q[0] <= vcur;
      for (int j = 1; j < SPAN; j++) begin
        win_q[j] <= win_q[j-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // s2: walk the due results in row then column order
  // --------------------------------------------------------------------------
  logic [smx_pkg::ROW_W-1:0] row2_q;
  logic [CW-1:0]             col2_q;
  logic [KW-1:0]             krlo2_q, kchi2_q, kclo2_q, kr_q, kc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_q <= due1_q;
    end else if (s2_done) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      row2_q  <= row1_q;
      col2_q  <= col1_q;
      krlo2_q <= krlo1_q;
      kchi2_q <= kchi1_q;
      kclo2_q <= kclo1_q;
      kr_q    <= krhi1_q;
      kc_q    <= kchi1_q;
    end else if (s2_go && !s2_last) begin
      // offsets count down, so row and column count up
      if (kc_q == kclo2_q) begin
        kc_q <= kchi2_q;
        kr_q <= kr_q - KW'(1);
      end else begin
        kc_q <= kc_q - KW'(1);
      end
    end
  end

  assign s2_last = (kr_q == krlo2_q) && (kc_q == kclo2_q);

  // horizontal suffix maxima per row offset, columns left of the frame skipped
  smx_pkg::pix_t hp [NV][SPAN];
  smx_pkg::pix_t res_max;

  always_comb begin
    for (int k = 0; k < NV; k++) begin
      hp[k][0] = win_q[0][k];
      for (int j = 1; j < SPAN; j++) begin
        hp[k][j] = ((col2_q >= CW'(j)) && (win_q[j][k] > hp[k][j-1])) ?
                   win_q[j][k] : hp[k][j-1];
      end
    end
    res_max = hp[0][RADIUS];
    for (int k = 0; k < NV; k++) begin
      for (int c = 0; c < NV; c++) begin
        if ((kr_q == KW'(k)) && (kc_q == KW'(c))) begin
          res_max = hp[k][c + RADIUS];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic [smx_pkg::ROW_W-1:0] out_row_q;
  logic [smx_pkg::COL_W-1:0] out_col_q;
  smx_pkg::pix_t             out_max_q;
  logic                      out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      out_row_q  <= row2_q - smx_pkg::ROW_W'(kr_q);
      out_col_q  <= smx_pkg::COL_W'(col2_q - CW'(kc_q));
      out_max_q  <= res_max;
      out_last_q <= s2_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign window_max_o  = out_max_q;
  assign last_of_run_o = out_last_q;

endmodule

>>> sv/smx_checker.sv
// ----------------------------------------------------------------------------
// smx_checker
// port-level checks of the sliding max core, bound to its top level
// ----------------------------------------------------------------------------
module smx_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [smx_pkg::ROW_W-1:0] out_row_o,
  input logic [smx_pkg::COL_W-1:0] out_col_o,
  input logic                      last_of_run_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_row_o) && $stable(out_col_o))
    else $error("result changed while stalled");

  // input is only held back while results are pending
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> out_valid_o)
    else $error("input held with no result on the way");

  // a run continues without a gap
  a_run_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_run_o |=> out_valid_o)
    else $error("gap inside a run of results");

  // within a run positions increase in raster order
  a_run_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_run_o |=>
      (out_row_o > $past(out_row_o)) ||
      ((out_row_o == $past(out_row_o)) && (out_col_o > $past(out_col_o))))
    else $error("results of a run out of order");

endmodule

bind sliding_max_5x5_core smx_checker u_smx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .out_row_o     (out_row_o),
  .out_col_o     (out_col_o),
  .last_of_run_o (last_of_run_o)
);

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the 5x5 sliding maximum core: a behavioural
// predictor of the clipped window maximum checks every result request in
// order, across many frame sizes, border shapes and out-of-frame drops
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W = 1024;
  localparam int RAD   = 2;
  localparam int SPAN  = 2 * RAD + 1;

  // index with no register behind it, writes to it must be ignored
  localparam logic [smx_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  // cycles with no request accepted on any channel before the run is abandoned;
  // the longest honest quiet spell is the output hold below plus a drain pause
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_PAD     = 16;
  localparam int RANDOM_TARGET = 200;

  // pixel mixes used when filling a frame
  localparam int MIX_FULL     = 0;
  localparam int MIX_EXTREME  = 1;
  localparam int MIX_GRADIENT = 2;
  localparam int MIX_NEGATIVE = 3;
  localparam int MIX_ANY      = 4;

  typedef enum int {RX_STREAM, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_e;

  typedef struct {
    logic [smx_pkg::ROW_W-1:0] row;
    logic [smx_pkg::COL_W-1:0] col;
    smx_pkg::pix_t             peak;
    logic                      last;
  } window_result_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [smx_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [smx_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  smx_pkg::pix_t                  pixel_value_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [smx_pkg::ROW_W-1:0]      out_row_o;
  logic [smx_pkg::COL_W-1:0]      out_col_o;
  smx_pkg::pix_t                  window_max_o;
  logic                           last_of_run_o;

  sliding_max_5x5_core #(
    .MAX_WIDTH (MAX_W),
    .RADIUS    (RAD)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_value_i (pixel_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .window_max_o  (window_max_o),
    .last_of_run_o (last_of_run_o)
  );

  // --------------------------------------------------------------------------
  // predictor state: its own copy of the registers, the raster position and
  // the last SPAN rows of pixels (row y lives in slot y mod SPAN)
  // --------------------------------------------------------------------------
  logic [smx_pkg::FW_W-1:0] frame_w_reg;
  logic [smx_pkg::FH_W-1:0] frame_h_reg;
  int unsigned              row_pos;
  int unsigned              col_pos;
  smx_pkg::pix_t            pixel_rows [SPAN][MAX_W];

  window_result_t  pending_max_q[$];

  // bookkeeping
  int mismatches;
  int results_checked;
  int pixels_sent;
  int pixels_dropped;
  int settings_used;
  int stall_cycles;
  int hold_request;

  // sender pacing, shared by every test
  bit sender_gaps;
  int burst_left;

  // --------------------------------------------------------------------------
  // clock, 2 ns period
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // first and last result index due along one axis when position p of an
  // extent n arrives; the final position flushes the whole trailing border
  function automatic bit due_span(input int unsigned p, input int unsigned n,
                                  output int unsigned lo, output int unsigned hi);
    if (p == n - 1) begin
      lo = (n - 1 >= RAD) ? n - 1 - RAD : 0;
      hi = n - 1;
      return 1'b1;
    end
    if (p < RAD) return 1'b0;
    lo = p - RAD;
    hi = p - RAD;
    return 1'b1;
  endfunction

  // maximum over the window around (y,x), clipped to a w by h frame
  function automatic smx_pkg::pix_t clipped_max(input int unsigned y, input int unsigned x,
                                                input int unsigned w, input int unsigned h);
    int unsigned   y0, y1, x0, x1, yy, xx;
    smx_pkg::pix_t peak;
    y0   = (y >= RAD) ? y - RAD : 0;
    y1   = (y + RAD >= h) ? h - 1 : y + RAD;
    x0   = (x >= RAD) ? x - RAD : 0;
    x1   = (x + RAD >= w) ? w - 1 : x + RAD;
    peak = pixel_rows[y0 % SPAN][x0];
    for (yy = y0; yy <= y1; yy++)
      for (xx = x0; xx <= x1; xx++)
        if (pixel_rows[yy % SPAN][xx] > peak) peak = pixel_rows[yy % SPAN][xx];
    return peak;
  endfunction

  // one accepted pixel: store it, queue every window maximum it completes,
  // and step the raster position
  function automatic void predict_window_max(input smx_pkg::pix_t value);
    int unsigned    w, h, r, c, ylo, yhi, xlo, xhi, y, x;
    bit             rows_due, cols_due;
    window_result_t res;
    w = (frame_w_reg == 0) ? 1 : frame_w_reg;
    if (w > MAX_W) w = MAX_W;
    h = (frame_h_reg == 0) ? 1 : frame_h_reg;
    r = row_pos;
    c = col_pos;
    // position outside the frame after a register change: pixel is dropped
    if (r >= h) begin
      row_pos = 0;
      col_pos = 0;
      pixels_dropped++;
      return;
    end
    if (c >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
      pixels_dropped++;
      return;
    end
    pixel_rows[r % SPAN][c] = value;
    rows_due = due_span(r, h, ylo, yhi);
    cols_due = due_span(c, w, xlo, xhi);
    if (rows_due && cols_due) begin
      for (y = ylo; y <= yhi; y++)
        for (x = xlo; x <= xhi; x++) begin
          res.row  = y[smx_pkg::ROW_W-1:0];
          res.col  = x[smx_pkg::COL_W-1:0];
          res.peak = clipped_max(y, x, w, h);
          res.last = (y == yhi) && (x == xhi);
          pending_max_q.push_back(res);
        end
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // result checker: every accepted result request against the oldest
  // expectation, field by field
  // --------------------------------------------------------------------------
  function automatic void report_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
  endfunction

  always @(posedge clk_i) begin
    window_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_max_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual row %0d col %0d max 0x%0h",
                 $time, out_row_o, out_col_o, window_max_o);
      end else begin
        want = pending_max_q.pop_front();
        results_checked++;
        if (out_row_o !== want.row)
          report_field("out_row", 32'(want.row), 32'(out_row_o));
        if (out_col_o !== want.col)
          report_field("out_col", 32'(want.col), 32'(out_col_o));
        if (window_max_o !== want.peak)
          report_field("window_max", 32'(want.peak), 32'(window_max_o));
        if (last_of_run_o !== want.last)
          report_field("last_of_run", 32'(want.last), 32'(last_of_run_o));
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: counts cycles in which no request moves on any channel
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending_max_q.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // receiver: drifts between stall patterns of its own; a hold request from a
  // test forces ready low for a counted stretch so the core backs up
  // --------------------------------------------------------------------------
  initial begin : receiver
    rx_mode_e mode;
    int       mode_left;
    int       hold_left;
    int       tick;
    out_ready_i = 1'b0;
    mode        = RX_STREAM;
    mode_left   = 0;
    hold_left   = 0;
    tick        = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      tick++;
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          RX_STREAM:   out_ready_i = 1'b1;
          RX_RANDOM:   out_ready_i = ($urandom_range(0, 9) >= 3);
          RX_PERIODIC: out_ready_i = (tick % 3 != 2);
          default:     out_ready_i = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // driver tasks: everything changes on the falling edge
  // --------------------------------------------------------------------------

  // one pixel request; the sender works in bursts with random gaps between
  task automatic send_pixel(input smx_pkg::pix_t value);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = sender_gaps ? $urandom_range(0, 12) : 0;
    end
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    = 1'b1;
    pixel_value_i = value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_window_max(value);
    pixels_sent++;
    burst_left--;
  endtask

  // sender stops offering and waits for every expected result, then lets the
  // pipeline settle in case the last pixels caused nothing
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_max_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [smx_pkg::CFG_IDX_W-1:0] index,
                           input logic [smx_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (index == smx_pkg::CFG_FRAME_WIDTH)       frame_w_reg = data[smx_pkg::FW_W-1:0];
    else if (index == smx_pkg::CFG_FRAME_HEIGHT) frame_h_reg = data[smx_pkg::FH_W-1:0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // a frame left part-way: shrink the frame under the current position so
  // that one dropped pixel brings the raster back to (0,0)
  task automatic return_to_origin();
    if (row_pos == 0 && col_pos == 0) return;
    wait_drained();
    if (row_pos != 0) begin
      write_reg(smx_pkg::CFG_FRAME_HEIGHT, row_pos[smx_pkg::CFG_DATA_W-1:0]);
    end else begin
      write_reg(smx_pkg::CFG_FRAME_HEIGHT, 16'd1);
      write_reg(smx_pkg::CFG_FRAME_WIDTH, col_pos[smx_pkg::CFG_DATA_W-1:0]);
    end
    send_pixel(smx_pkg::pix_t'($urandom));
  endtask

  task automatic start_frame(input logic [smx_pkg::CFG_DATA_W-1:0] width_raw,
                             input logic [smx_pkg::CFG_DATA_W-1:0] height_raw);
    return_to_origin();
    wait_drained();
    write_reg(smx_pkg::CFG_FRAME_WIDTH, width_raw);
    write_reg(smx_pkg::CFG_FRAME_HEIGHT, height_raw);
    settings_used++;
  endtask

  function automatic smx_pkg::pix_t random_pixel(input int mix);
    int            pick;
    int            level;
    smx_pkg::pix_t value;
    pick = (mix == MIX_ANY) ? $urandom_range(MIX_FULL, MIX_NEGATIVE) : mix;
    case (pick)
      MIX_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       value = 32'sh7FFF_FFFF;
          1:       value = 32'sh8000_0000;
          2:       value = 32'sh0000_0000;
          default: value = -32'sd1;
        endcase
      end
      MIX_GRADIENT: begin
        // Q24.8 values near zero, so neighbouring maxima differ by little
        level = int'($urandom_range(0, 4000)) - 2000;
        value = smx_pkg::pix_t'(level * 256 + int'($urandom_range(0, 255)));
      end
      MIX_NEGATIVE: begin
        value     = smx_pkg::pix_t'($urandom);
        value[31] = 1'b1;
      end
      default: value = smx_pkg::pix_t'($urandom);
    endcase
    return value;
  endfunction

  task automatic send_frame_pixels(input int count, input int mix);
    repeat (count) send_pixel(random_pixel(mix));
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // registers straight out of reset (1024 x 1024): a few pixels, no results
  task automatic test_reset_defaults();
    send_pixel(32'sh7FFF_FFFF);
    send_pixel(32'sh8000_0000);
    send_pixel(32'sh0000_0000);
    settings_used++;
  endtask

  // signed extremes and alternating bit patterns in a 5 x 3 frame; the
  // width is written with junk above its 11 bits
  task automatic test_pixel_extremes();
    smx_pkg::pix_t values [15] = '{
      32'sh8000_0000, 32'sh8000_0000, -32'sd1,        32'sh8000_0001, 32'sh8000_0000,
      32'shAAAA_AAAA, 32'sh5555_5555, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'sh8000_0000,
      32'sh8000_0000, -32'sd1,        32'sh0000_0001, 32'shFFFF_FF00, 32'sh8000_0000
    };
    start_frame(16'hF805, 16'd3);
    foreach (values[i]) send_pixel(values[i]);
  endtask

  // width zero, height zero, single pixel frame, and a write to a spare index
  task automatic test_degenerate_sizes();
    start_frame(16'd0, 16'd4);
    send_pixel(-32'sd1);
    send_pixel(32'sh8000_0000);
    send_pixel(32'sh7FFF_FFFF);
    send_pixel(32'sh0000_0000);
    start_frame(16'd7, 16'd0);
    send_frame_pixels(7, MIX_EXTREME);
    start_frame(16'd1, 16'd1);
    wait_drained();
    write_reg(CFG_SPARE_IDX, 16'hFFFF);
    send_pixel(32'sh1234_5678);
  endtask

  // drops with a following row still inside the frame, then a row overflow
  task automatic test_out_of_frame();
    start_frame(16'd4, 16'd50);
    send_frame_pixels(6, MIX_FULL);
    wait_drained();
    // column beyond the narrowed width: moves to the start of the next row
    write_reg(smx_pkg::CFG_FRAME_WIDTH, 16'd2);
    send_pixel(32'sh0BAD_0BAD);
    wait_drained();
    // row beyond the shortened height: moves back to (0,0)
    write_reg(smx_pkg::CFG_FRAME_HEIGHT, 16'd2);
    send_pixel(32'sh0BAD_0BAD);
    start_frame(16'd4, 16'd50);
    send_frame_pixels(13, MIX_ANY);
    return_to_origin();
  endtask

  // widest and tallest settings, with short partial frames
  task automatic test_extreme_sizes();
    start_frame(16'd1024, 16'd1);
    send_frame_pixels(30, MIX_ANY);
    start_frame(16'd2047, 16'd1);
    send_frame_pixels(25, MIX_GRADIENT);
    start_frame(16'd3, 16'd65535);
    send_frame_pixels(18, MIX_NEGATIVE);
    return_to_origin();
  endtask

  // output held off for a long stretch while pixels keep coming, then the
  // sender pauses until everything has drained
  task automatic test_backpressure();
    sender_gaps = 1'b0;
    start_frame(16'd8, 16'd6);
    hold_request = HOLD_CYCLES;
    send_frame_pixels(48, MIX_ANY);
    wait_drained();
    sender_gaps = 1'b1;
  endtask

  // random frames: mostly small complete frames, some wider ones, some left
  // part-way, some with zero-coded sizes
  task automatic test_random_frames();
    int start_count;
    int kind;
    int w, h, count;
    start_count = pixels_sent;
    while (pixels_sent - pixels_dropped - start_count < RANDOM_TARGET) begin
      kind        = $urandom_range(0, 99);
      sender_gaps = ($urandom_range(0, 3) != 0);
      if (kind < 70) begin
        w     = $urandom_range(1, 12);
        h     = $urandom_range(1, 8);
        count = w * h;
      end else if (kind < 85) begin
        w     = $urandom_range(13, 40);
        h     = $urandom_range(1, 4);
        count = w * h;
      end else if (kind < 95) begin
        w     = $urandom_range(1, 16);
        h     = $urandom_range(2, 40);
        count = $urandom_range(1, w * h - 1);
      end else begin
        w     = $urandom_range(0, 6);
        h     = (w == 0) ? $urandom_range(1, 6) : 0;
        count = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      end
      start_frame(w[smx_pkg::CFG_DATA_W-1:0], h[smx_pkg::CFG_DATA_W-1:0]);
      send_frame_pixels(count, $urandom_range(MIX_FULL, MIX_ANY));
    end
    sender_gaps = 1'b1;
    return_to_origin();
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    // every input known from time zero
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = smx_pkg::CFG_FRAME_WIDTH;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    pixel_value_i = '0;

    // predictor reset state
    frame_w_reg    = smx_pkg::FW_RESET;
    frame_h_reg    = smx_pkg::FH_RESET;
    row_pos        = 0;
    col_pos        = 0;
    foreach (pixel_rows[i, j]) pixel_rows[i][j] = '0;
    mismatches     = 0;
    results_checked = 0;
    pixels_sent    = 0;
    pixels_dropped = 0;
    settings_used  = 0;
    hold_request   = 0;
    sender_gaps    = 1'b1;
    burst_left     = 0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_pixel_extremes();
    test_degenerate_sizes();
    test_out_of_frame();
    test_extreme_sizes();
    test_backpressure();
    test_random_frames();
    wait_drained();

    $display("covered %0d pixel requests (%0d dropped outside the frame) over %0d frame settings",
             pixels_sent, pixels_dropped, settings_used);
    $display("checked %0d window maxima, borders clipped, %0d-cycle output hold included",
             results_checked, HOLD_CYCLES);
    if (mismatches == 0 && pending_max_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
sv/smx_pkg.sv
sv/sliding_max_5x5_core.sv
sv/smx_checker.sv
dv/testbench.sv
